// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they compile away under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Codes, character constants and types of the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  // parse phases
  localparam logic [4:0] PH_START  = 5'd0;
  localparam logic [4:0] PH_GET_E  = 5'd1;
  localparam logic [4:0] PH_GET_T  = 5'd2;
  localparam logic [4:0] PH_HEAD_E = 5'd3;
  localparam logic [4:0] PH_HEAD_A = 5'd4;
  localparam logic [4:0] PH_HEAD_D = 5'd5;
  localparam logic [4:0] PH_POST_O = 5'd6;
  localparam logic [4:0] PH_POST_S = 5'd7;
  localparam logic [4:0] PH_POST_T = 5'd8;
  localparam logic [4:0] PH_SKIP1  = 5'd9;
  localparam logic [4:0] PH_PATH   = 5'd10;
  localparam logic [4:0] PH_SKIP2  = 5'd11;
  localparam logic [4:0] PH_VER_T1 = 5'd12;
  localparam logic [4:0] PH_VER_T2 = 5'd13;
  localparam logic [4:0] PH_VER_P  = 5'd14;
  localparam logic [4:0] PH_VER_SL = 5'd15;
  localparam logic [4:0] PH_MAJOR  = 5'd16;
  localparam logic [4:0] PH_DOT    = 5'd17;
  localparam logic [4:0] PH_MINOR  = 5'd18;
  localparam logic [4:0] PH_IGNORE = 5'd19;

  // result kinds
  localparam logic [1:0] KIND_PATH  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // method codes
  localparam logic [1:0] METHOD_GET  = 2'd0;
  localparam logic [1:0] METHOD_HEAD = 2'd1;
  localparam logic [1:0] METHOD_POST = 2'd2;

  // version codes
  localparam logic [1:0] VER_1_0 = 2'd0;
  localparam logic [1:0] VER_1_1 = 2'd1;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;

  typedef struct packed {
    logic [4:0] phase;
    logic [1:0] method;
    logic [1:0] major;
  } parse_state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] path_char;
    logic [1:0] method;
    logic [1:0] version;
  } result_t;

endpackage

// File: rtl/core/hrlp_step.sv
// ----------------------------------------------------------------------------
// hrlp_step
// Next-state and result logic for one request character.
// ----------------------------------------------------------------------------
module hrlp_step (
  input  hrlp_pkg::parse_state_t cur,
  input  logic [7:0]             char_in,
  output hrlp_pkg::parse_state_t nxt,
  output hrlp_pkg::result_t      res
);
  import hrlp_pkg::*;

  logic [7:0] digit_off;
  logic       fail;

  assign digit_off = char_in - CH_1;

  always_comb begin
    nxt  = cur;
    res  = '0;
    fail = 1'b0;
    if (char_in == CH_NUL) begin
      nxt.phase  = PH_START;
      nxt.method = METHOD_GET;
      nxt.major  = 2'd0;
      if (cur.phase < PH_IGNORE) begin
        res.valid = 1'b1;
        res.kind  = KIND_ERROR;
      end
    end else begin
      unique case (cur.phase)
        PH_START: begin
          if (char_in == CH_G) begin
            nxt.method = METHOD_GET;
            nxt.phase  = PH_GET_E;
          end else if (char_in == CH_H) begin
            nxt.method = METHOD_HEAD;
            nxt.phase  = PH_HEAD_E;
          end else if (char_in == CH_P) begin
            nxt.method = METHOD_POST;
            nxt.phase  = PH_POST_O;
          end else begin
            fail = 1'b1;
          end
        end
        PH_GET_E:  if (char_in == CH_E) nxt.phase = PH_GET_T;  else fail = 1'b1;
        PH_GET_T:  if (char_in == CH_T) nxt.phase = PH_SKIP1;  else fail = 1'b1;
        PH_HEAD_E: if (char_in == CH_E) nxt.phase = PH_HEAD_A; else fail = 1'b1;
        PH_HEAD_A: if (char_in == CH_A) nxt.phase = PH_HEAD_D; else fail = 1'b1;
        PH_HEAD_D: if (char_in == CH_D) nxt.phase = PH_SKIP1;  else fail = 1'b1;
        PH_POST_O: if (char_in == CH_O) nxt.phase = PH_POST_S; else fail = 1'b1;
        PH_POST_S: if (char_in == CH_S) nxt.phase = PH_POST_T; else fail = 1'b1;
        PH_POST_T: if (char_in == CH_T) nxt.phase = PH_SKIP1;  else fail = 1'b1;
        PH_SKIP1, PH_PATH: begin
          if (char_in == CH_SPACE) begin
            if (cur.phase == PH_PATH) nxt.phase = PH_SKIP2;
          end else begin
            nxt.phase     = PH_PATH;
            res.valid     = 1'b1;
            res.kind      = KIND_PATH;
            res.path_char = char_in;
          end
        end
        PH_SKIP2: begin
          if (char_in == CH_H) nxt.phase = PH_VER_T1;
          else if (char_in != CH_SPACE) fail = 1'b1;
        end
        PH_VER_T1: if (char_in == CH_T) nxt.phase = PH_VER_T2;     else fail = 1'b1;
        PH_VER_T2: if (char_in == CH_T) nxt.phase = PH_VER_P;      else fail = 1'b1;
        PH_VER_P:  if (char_in == CH_P) nxt.phase = PH_VER_SL;     else fail = 1'b1;
        PH_VER_SL: if (char_in == CH_SLASH) nxt.phase = PH_MAJOR;  else fail = 1'b1;
        PH_MAJOR: begin
          if (char_in >= CH_1 && char_in <= CH_3) begin
            nxt.major = digit_off[1:0];
            nxt.phase = PH_DOT;
          end else begin
            fail = 1'b1;
          end
        end
        PH_DOT: if (char_in == CH_DOT) nxt.phase = PH_MINOR; else fail = 1'b1;
        PH_MINOR: begin
          if (char_in == CH_0 || (char_in == CH_1 && cur.major == 2'd0)) begin
            nxt.phase  = PH_IGNORE;
            res.valid  = 1'b1;
            res.kind   = KIND_DONE;
            res.method = cur.method;
            if (cur.major == 2'd0) begin
              res.version = (char_in == CH_1) ? VER_1_1 : VER_1_0;
            end else begin
              // 2.0 and 3.0 take the code equal to their major digit, one above the stored major
              res.version = cur.major + 2'd1;
            end
          end else begin
            fail = 1'b1;
          end
        end
        default: ;  // ignore phase: drop everything up to the terminator
      endcase
      if (fail) begin
        nxt.phase = PH_IGNORE;
        res       = '0;
        res.valid = 1'b1;
        res.kind  = KIND_ERROR;
      end
    end
  end

endmodule

// File: rtl/core/http_request_line_parser_unit.sv
// ----------------------------------------------------------------------------
// http_request_line_parser_unit
// Request-line parser: method, path stream and protocol version.
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// --------+----------------------+---------------------------------------------
// input   | in_valid / in_ready  | char_in
// output  | out_valid / out_ready| kind, path_char, method_code, version_code
//
// One item per cycle sustained while out_ready stays high; an accepted item
// goes into the input register, then its result into the result register.
// The next-state logic in hrlp_step takes one phase step per item.
// rst is synchronous and clears the valid flags and the parse state.
// A stalled result holds the input register; one more item may wait there.
// Items that give no result still pass the result stage, so order is kept.
// ----------------------------------------------------------------------------
module http_request_line_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] path_char,
  output logic [1:0] method_code,
  output logic [1:0] version_code
);
  import hrlp_pkg::*;

  `include "assert_macros.svh"

  // input register
  logic         hold_valid;
  logic [7:0]   hold_char;

  // parse state and step results
  parse_state_t state;
  parse_state_t state_next;
  result_t      step_res;

  // result register
  result_t      res;
  logic         advance;

  // the held item moves on once the result register is free or being emptied
  assign advance  = hold_valid && (!res.valid || out_ready);
  assign in_ready = !hold_valid || advance;

  hrlp_step u_step (
    .cur     (state),
    .char_in (hold_char),
    .nxt     (state_next),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      hold_char <= char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase  <= PH_START;
      state.method <= METHOD_GET;
      state.major  <= 2'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= step_res.valid;
    end else if (out_ready) begin
      res.valid <= 1'b0;
    end
    if (advance && step_res.valid) begin
      res.kind      <= step_res.kind;
      res.path_char <= step_res.path_char;
      res.method    <= step_res.method;
      res.version   <= step_res.version;
    end
  end

  assign out_valid    = res.valid;
  assign kind         = res.kind;
  assign path_char    = res.path_char;
  assign method_code  = res.method;
  assign version_code = res.version;

  // a terminator always sends the parser back to the start
  `ASSERT_NEXT(a_term_restart, clk, rst,
               advance && hold_char == CH_NUL, state.phase == PH_START)
  // a done result is only shown while the parser sits in the ignore phase
  `ASSERT_ALWAYS(a_done_ignore, clk, rst,
                 !(out_valid && kind == KIND_DONE) || state.phase == PH_IGNORE)
  // path results carry no method or version
  `ASSERT_ALWAYS(a_path_clean, clk, rst,
                 !(out_valid && kind == KIND_PATH) ||
                 (method_code == METHOD_GET && version_code == VER_1_0))
  // only the three result kinds are ever shown
  `ASSERT_ALWAYS(a_kind_legal, clk, rst,
                 !out_valid || kind == KIND_PATH || kind == KIND_DONE || kind == KIND_ERROR)

endmodule

// File: tb/http_request_line_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// http_request_line_parser_unit_tb
// Self-checking bench for the request-line parser. A directed burst covers
// empty requests, empty paths, high path bytes and trailing characters.
// Random requests follow: mostly well-formed lines with random content, plus
// corrupted, truncated and noise lines. A scoreboard class tracks the parse
// and compares each result in order. Both sides idle and stall at random, and
// one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module http_request_line_parser_unit_tb;
  import hrlp_pkg::*;

  // version codes and digits that the package does not name
  localparam logic [1:0] VER_2_0 = 2'd2;
  localparam logic [1:0] VER_3_0 = 2'd3;
  localparam logic [7:0] CH_2    = 8'h32;
  localparam logic [7:0] CH_4    = 8'h34;

  localparam int ITEMS_PER_PASS = 450;   // three random passes, about 1350 useful items
  localparam int HOLD_AT_RESULT = 120;   // result count that starts the long hold
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 10;    // two-stage pipe, plus margin
  localparam int CYCLE_LIMIT    = 200000;
  localparam int REPORT_LIMIT   = 30;

  // --------------------------------------------------------------------------
  // Parse tracker: follows the request line item by item, queues the result
  // each accepted character should give and checks results as they leave.
  // --------------------------------------------------------------------------
  class line_result_tracker;
    logic [4:0] phase;
    logic [1:0] method_seen;
    logic [1:0] major_seen;
    result_t    awaited[$];
    int         errors;
    int         checked;

    function new();
      restart();
      errors  = 0;
      checked = 0;
    endfunction

    function void restart();
      phase       = PH_START;
      method_seen = METHOD_GET;
      major_seen  = 2'd0;
    endfunction

    function void await_result(logic [1:0] k, logic [7:0] pc, logic [1:0] m,
                               logic [1:0] v);
      result_t r;
      r.valid     = 1'b1;
      r.kind      = k;
      r.path_char = pc;
      r.method    = m;
      r.version   = v;
      awaited.push_back(r);
    endfunction

    // literal match: step on if the wanted character came, else report failure
    function bit advance(logic [7:0] c, logic [7:0] want, logic [4:0] nxt);
      if (c != want) return 1'b0;
      phase = nxt;
      return 1'b1;
    endfunction

    function void take_char(logic [7:0] c);
      bit         fail;
      logic [7:0] digit;
      logic [1:0] ver;
      fail  = 1'b0;
      digit = c - CH_1;
      ver   = VER_1_0;
      // terminator: error unless the line already finished, then back to start
      if (c == CH_NUL) begin
        if (phase < PH_IGNORE) await_result(KIND_ERROR, 8'd0, 2'd0, 2'd0);
        restart();
        return;
      end
      case (phase)
        PH_START: begin
          if (c == CH_G) begin
            method_seen = METHOD_GET;
            phase = PH_GET_E;
          end else if (c == CH_H) begin
            method_seen = METHOD_HEAD;
            phase = PH_HEAD_E;
          end else if (c == CH_P) begin
            method_seen = METHOD_POST;
            phase = PH_POST_O;
          end else begin
            fail = 1'b1;
          end
        end
        PH_GET_E:  fail = !advance(c, CH_E, PH_GET_T);
        PH_GET_T:  fail = !advance(c, CH_T, PH_SKIP1);
        PH_HEAD_E: fail = !advance(c, CH_E, PH_HEAD_A);
        PH_HEAD_A: fail = !advance(c, CH_A, PH_HEAD_D);
        PH_HEAD_D: fail = !advance(c, CH_D, PH_SKIP1);
        PH_POST_O: fail = !advance(c, CH_O, PH_POST_S);
        PH_POST_S: fail = !advance(c, CH_S, PH_POST_T);
        PH_POST_T: fail = !advance(c, CH_T, PH_SKIP1);
        PH_SKIP1: begin
          if (c != CH_SPACE) begin
            phase = PH_PATH;
            await_result(KIND_PATH, c, 2'd0, 2'd0);
          end
        end
        PH_PATH: begin
          if (c == CH_SPACE) phase = PH_SKIP2;
          else await_result(KIND_PATH, c, 2'd0, 2'd0);
        end
        PH_SKIP2: begin
          if (c != CH_SPACE) fail = !advance(c, CH_H, PH_VER_T1);
        end
        PH_VER_T1: fail = !advance(c, CH_T, PH_VER_T2);
        PH_VER_T2: fail = !advance(c, CH_T, PH_VER_P);
        PH_VER_P:  fail = !advance(c, CH_P, PH_VER_SL);
        PH_VER_SL: fail = !advance(c, CH_SLASH, PH_MAJOR);
        PH_MAJOR: begin
          if (c >= CH_1 && c <= CH_3) begin
            major_seen = digit[1:0];
            phase = PH_DOT;
          end else begin
            fail = 1'b1;
          end
        end
        PH_DOT: fail = !advance(c, CH_DOT, PH_MINOR);
        PH_MINOR: begin
          // 1.0 and 1.1 for major 1; only x.0 for majors 2 and 3
          if (c == CH_0 || (c == CH_1 && major_seen == 2'd0)) begin
            if (major_seen == 2'd0) ver = (c == CH_1) ? VER_1_1 : VER_1_0;
            else ver = major_seen + 2'd1;
            phase = PH_IGNORE;
            await_result(KIND_DONE, 8'd0, method_seen, ver);
          end else begin
            fail = 1'b1;
          end
        end
        default: ;
      endcase
      if (fail) begin
        phase = PH_IGNORE;
        await_result(KIND_ERROR, 8'd0, 2'd0, 2'd0);
      end
    endfunction

    function void field_check(string field, int want, int got);
      if (want != got) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [1:0] k, logic [7:0] pc, logic [1:0] m,
                               logic [1:0] v);
      result_t w;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result, expected none, actual kind %0h char %0h m %0h v %0h",
                   $time, k, pc, m, v);
        return;
      end
      w = awaited.pop_front();
      field_check("kind", w.kind, k);
      field_check("path_char", w.path_char, pc);
      field_check("method_code", w.method, m);
      field_check("version_code", w.version, v);
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] char_in;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] kind;
  logic [7:0] path_char;
  logic [1:0] method_code;
  logic [1:0] version_code;

  http_request_line_parser_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_in     (char_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .path_char   (path_char),
    .method_code (method_code),
    .version_code(version_code)
  );

  line_result_tracker tracker = new();

  logic [7:0] line_q[$];      // characters of the request being sent
  int         useful_items;   // items sent that the block does not just ignore
  int         send_idle_pct;  // chance per item that the sender idles first
  int         stall_pct;      // chance per cycle that the receiver stalls

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends here
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("http_request_line_parser_unit regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Offer one character, idling first at random; valid stays up until taken.
  // Inputs are sampled just after the edge, so they hold their pre-edge value.
  task automatic send_char(logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    do @(posedge clk); while (!in_ready);
    tracker.take_char(c);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
  endtask

  // Sender pause: wait for every outstanding result. At least one edge passes,
  // so valid is never dropped and raised in the same step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] path_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1)); while (c == CH_SPACE);
    return c;
  endfunction

  // One random request line. Most are well formed; the rest have one byte
  // replaced, are cut short by an early terminator, or are plain noise.
  function automatic void build_request();
    logic [1:0] m;
    logic [1:0] v;
    int         style;
    int         junk;
    int         pos;
    int         n;
    line_q.delete();
    m     = 2'($urandom_range(2));
    v     = 2'($urandom_range(3));
    style = $urandom_range(99);
    junk  = $urandom_range(2);
    case (m)
      METHOD_GET:  push_text("GET");
      METHOD_HEAD: push_text("HEAD");
      default:     push_text("POST");
    endcase
    n = ($urandom_range(3) == 0) ? 0 : $urandom_range(2, 1);
    repeat (n) line_q.push_back(CH_SPACE);
    n = $urandom_range(6, 1);
    repeat (n) line_q.push_back(path_byte());
    n = $urandom_range(2, 1);
    repeat (n) line_q.push_back(CH_SPACE);
    push_text("HTTP/");
    if ($urandom_range(5) == 0) begin
      // near misses around the accepted versions
      line_q.push_back(8'($urandom_range(CH_4, CH_0)));
      line_q.push_back(CH_DOT);
      line_q.push_back(8'($urandom_range(CH_2, CH_0)));
    end else begin
      case (v)
        VER_1_0: push_text("1.0");
        VER_1_1: push_text("1.1");
        VER_2_0: push_text("2.0");
        default: push_text("3.0");
      endcase
    end
    repeat (junk) line_q.push_back(path_byte());
    line_q.push_back(CH_NUL);
    if (style >= 93) begin
      line_q.delete();
      n = $urandom_range(6, 1);
      repeat (n) line_q.push_back(8'($urandom_range(255)));
      line_q.push_back(CH_NUL);
      junk = 0;
    end else if (style >= 85) begin
      pos = $urandom_range(line_q.size() - 2);
      while (line_q.size() > pos + 1) void'(line_q.pop_back());
      line_q[pos] = CH_NUL;
      junk = 0;
    end else if (style >= 70) begin
      pos = $urandom_range(line_q.size() - 2);
      line_q[pos] = 8'($urandom_range(255));
    end
    useful_items += line_q.size() - junk;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: checks each result taken and chooses the next ready. Once, after
  // a fair number of results, it holds ready low long enough to back the block
  // up into its input while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        tracker.check_result(kind, path_char, method_code, version_code);
      if (!held && tracker.checked >= HOLD_AT_RESULT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (rst || hold_left > 0) begin
        out_ready <= 1'b0;
        if (hold_left > 0) hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    char_in       <= CH_NUL;
    useful_items  = 0;
    send_idle_pct = 8;
    stall_pct     = 77;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty request; terminator straight after the method; bad
    // method then a quiet terminator; no space after the method, high path
    // bytes, HTTP/3.0 and a trailing character ignored before the terminator
    line_q.delete();
    line_q.push_back(CH_NUL);
    push_text("GET");
    line_q.push_back(CH_NUL);
    push_text("P");
    line_q.push_back(8'hFF);
    line_q.push_back(CH_NUL);
    push_text("HEAD");
    line_q.push_back(8'hFF);
    line_q.push_back(8'h80);
    push_text(" HTTP/3.0x");
    line_q.push_back(CH_NUL);
    send_line();
    wait_drained();

    // random passes: sender idles lightly and receiver stalls heavily, then
    // the other way round, then both flat out
    for (int pass_no = 0; pass_no < 3; pass_no++) begin
      case (pass_no)
        0: begin send_idle_pct = 8;  stall_pct = 77; end
        1: begin send_idle_pct = 77; stall_pct = 8;  end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      while (useful_items < (pass_no + 1) * ITEMS_PER_PASS) begin
        build_request();
        send_line();
      end
      wait_drained();
    end

    // let any last item that gives no result clear the pipe
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("http_request_line_parser_unit regression: pass");
    else
      $display("http_request_line_parser_unit regression: fail");
    $finish;
  end

endmodule
